FILE: rtl/pixel_frame_packer_crc16_unit_macros.svh
// Assertion macros shared by the pixel frame packer RTL.
// No dependencies; the macros refer to the ports clock and reset by name.
`ifndef PIXEL_FRAME_PACKER_CRC16_UNIT_MACROS_SVH
`define PIXEL_FRAME_PACKER_CRC16_UNIT_MACROS_SVH

// Check a property on every rising edge, ignored while reset is high.
`define PFP_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define PFP_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: rtl/pfp_pkg.sv
// Package for the pixel frame packer: sizes, constants, queue item type,
// byte sequencer states and the byte-wise CRC-16 update. No dependencies.
`default_nettype none

package pfp_pkg;

   localparam int PIXELS_PER_FRAME = 768;
   localparam int IDX_W            = $clog2(PIXELS_PER_FRAME);
   localparam int PIX_W            = 16;
   localparam int FRM_W            = 16;
   localparam int BYTE_W           = 8;
   localparam int CRC_W            = 16;
   // queue depth, a power of two
   localparam int QDEPTH           = 2;
   localparam int QPTR_W           = $clog2(QDEPTH);

   localparam logic [CRC_W-1:0]  CRC_INIT  = 16'hFFFF;
   localparam logic [CRC_W-1:0]  CRC_POLY  = 16'h1021;
   localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h5A;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic [FRM_W-1:0] frame;
      logic             first;
      logic             last;
   } pfp_item_type;

   typedef enum logic [8:0] {
      ST_NEXT  = 9'b000000001,
      ST_HDR0  = 9'b000000010,
      ST_HDR1  = 9'b000000100,
      ST_FNLO  = 9'b000001000,
      ST_FNHI  = 9'b000010000,
      ST_PXLO  = 9'b000100000,
      ST_PXHI  = 9'b001000000,
      ST_CRCLO = 9'b010000000,
      ST_CRCHI = 9'b100000000
   } pfp_step_type;

   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0]  crc_i,
                                                 input logic [BYTE_W-1:0] data_i);
      logic [CRC_W-1:0] c;
      c = crc_i ^ {data_i, {(CRC_W-BYTE_W){1'b0}}};
      for (int k = 0; k < BYTE_W; k++) begin
         c = c[CRC_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/pixel_frame_packer_crc16_unit.sv
// Pixel frame packer with CRC-16 trailer, top level.
// Instantiates pfp_front, pfp_queue and pfp_back; uses pfp_pkg and the macros header.
//
// Each request word carries one 16-bit pixel and a frame number; the block
// turns it into bytes on the response channel, one byte per response word.
// The first pixel of a frame is preceded by 0x5A 0x5A and the frame number
// (low byte first); every pixel goes out low byte first; after the last pixel
// of a frame (PIXELS_PER_FRAME in the package) the CRC-16 over that frame's
// pixel bytes (poly 0x1021, init 0xFFFF, MSB first, no reflection, no final
// xor) follows, low byte first. rsp_run_end marks the last byte caused by a
// request word, rsp_frame_end marks the CRC high byte. A request yields six
// bytes on the first pixel of a frame, two on a middle pixel and four on the
// last. The byte-wide output register paces the stream, and the CRC unit
// updates one byte per cycle alongside it while the queue holds a word and
// the output register can take a byte. A two-word queue between the accepting
// front end and the byte sequencer lets requests come in while bytes are
// still draining; the first output byte of a request accepted into an empty block
// passes through the queue and then the output register. No configuration and no
// clearing pass after reset.
`default_nettype none

module pixel_frame_packer_crc16_unit (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [pfp_pkg::PIX_W-1:0] req_pixel_value,
   input  wire logic [pfp_pkg::FRM_W-1:0] req_frame_number,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [pfp_pkg::BYTE_W-1:0]     rsp_out_byte,
   output logic                           rsp_run_end,
   output logic                           rsp_frame_end
);
   import pfp_pkg::*;

`include "pixel_frame_packer_crc16_unit_macros.svh"

   pfp_item_type push_item;
   pfp_item_type head_item;
   logic         q_push;
   logic         q_full;
   logic         q_head_valid;
   logic         q_pop;

   // accept and tag the pixel word
   pfp_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pixel_value  (req_pixel_value),
      .req_frame_number (req_frame_number),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_item           (push_item)
   );

   // hold tagged words until the sequencer is ready for them
   pfp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (push_item),
      .full       (q_full),
      .head_valid (q_head_valid),
      .head_item  (head_item),
      .pop        (q_pop)
   );

   // emit header, pixel and CRC bytes
   pfp_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (q_head_valid),
      .head_item     (head_item),
      .pop           (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_run_end   (rsp_run_end),
      .rsp_frame_end (rsp_frame_end)
   );

   // a frame closes only on the last byte of its request word
   `PFP_ASSERT_RST(a_frame_end_run_end, (rsp_valid && rsp_frame_end) |-> rsp_run_end, "frame end without run end")
   // the sequencer retires a word only when the queue holds one
   `PFP_ASSERT_RST(a_pop_nonempty, q_pop |-> q_head_valid, "queue popped while empty")
   // the output register comes out of reset empty
   `PFP_ASSERT_ALWAYS(a_reset_empty, $past(reset) |-> !rsp_valid, "response valid after reset")

endmodule

`default_nettype wire

FILE: rtl/pfp_front.sv
// Front end: accepts pixel words and tags them as first / last of a frame.
// Depends on pfp_pkg.
`default_nettype none

module pfp_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [pfp_pkg::PIX_W-1:0]   req_pixel_value,
   input  wire logic [pfp_pkg::FRM_W-1:0]   req_frame_number,
   input  wire logic                        q_full,
   output logic                             q_push,
   output pfp_pkg::pfp_item_type            q_item
);
   import pfp_pkg::*;

   localparam logic [IDX_W:0] PPF_CNT = (IDX_W+1)'(PIXELS_PER_FRAME);

   logic [IDX_W-1:0] pixel_index_ff, pixel_index_in;
   logic [IDX_W:0]   index_next;
   logic             is_last;

   assign index_next = {1'b0, pixel_index_ff} + (IDX_W+1)'(1);
   assign is_last    = (index_next >= PPF_CNT);

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   assign q_item.pixel = req_pixel_value;
   assign q_item.frame = req_frame_number;
   assign q_item.first = (pixel_index_ff == '0);
   assign q_item.last  = is_last;

   always_comb begin
      pixel_index_in = pixel_index_ff;
      if (q_push) begin
         pixel_index_in = is_last ? '0 : index_next[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_index_ff <= '0;
      end else begin
         pixel_index_ff <= pixel_index_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/pfp_queue.sv
// Short flip-flop queue of tagged pixel words between front and back end.
// Depends on pfp_pkg.
`default_nettype none

module pfp_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire pfp_pkg::pfp_item_type push_item,
   output logic                       full,
   output logic                       head_valid,
   output pfp_pkg::pfp_item_type      head_item,
   input  wire logic                  pop
);
   import pfp_pkg::*;

   localparam logic [QPTR_W:0] QDEPTH_CNT = (QPTR_W+1)'(QDEPTH);

   pfp_item_type      slot_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   assign full       = (count_ff == QDEPTH_CNT);
   assign head_valid = (count_ff != '0);
   assign head_item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/pfp_back.sv
// Back end: sequencer emitting header, pixel and CRC bytes into a registered
// output word; the CRC takes one byte per unstalled cycle. Uses pfp_pkg.
`default_nettype none

module pfp_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       head_valid,
   input  wire pfp_pkg::pfp_item_type      head_item,
   output logic                            pop,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [pfp_pkg::BYTE_W-1:0]      rsp_out_byte,
   output logic                            rsp_run_end,
   output logic                            rsp_frame_end
);
   import pfp_pkg::*;

   pfp_step_type      step_ff, step_in, cur_step;
   logic [CRC_W-1:0]  crc_ff, crc_in, crc_src, crc_upd;
   logic [BYTE_W-1:0] crc_data;
   logic              out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic              run_end_ff, run_end_in;
   logic              frame_end_ff, frame_end_in;
   logic              slot_free, fire;
   logic [BYTE_W-1:0] gen_byte;
   logic              gen_run_end, gen_frame_end, gen_pop;
   pfp_step_type      gen_next;
   logic [CRC_W-1:0]  gen_crc;

   assign slot_free = !out_valid_ff || rsp_ready;
   assign fire      = head_valid && slot_free;
   assign pop       = fire && gen_pop;

   // between items, pick the entry step from the head word's tag
   assign cur_step = (step_ff == ST_NEXT) ? (head_item.first ? ST_HDR0 : ST_PXLO)
                                          : step_ff;

   // one shared byte-wise CRC update; the first pixel byte restarts it
   assign crc_src  = (cur_step == ST_PXLO && head_item.first) ? CRC_INIT : crc_ff;
   assign crc_data = (cur_step == ST_PXLO) ? head_item.pixel[BYTE_W-1:0]
                                           : head_item.pixel[2*BYTE_W-1:BYTE_W];
   assign crc_upd  = crc_byte(crc_src, crc_data);

   always_comb begin
      gen_byte      = '0;
      gen_run_end   = 1'b0;
      gen_frame_end = 1'b0;
      gen_pop       = 1'b0;
      gen_next      = ST_NEXT;
      gen_crc       = crc_ff;
      unique case (cur_step)
         ST_HDR0: begin
            gen_byte = SYNC_BYTE;
            gen_next = ST_HDR1;
         end
         ST_HDR1: begin
            gen_byte = SYNC_BYTE;
            gen_next = ST_FNLO;
         end
         ST_FNLO: begin
            gen_byte = head_item.frame[BYTE_W-1:0];
            gen_next = ST_FNHI;
         end
         ST_FNHI: begin
            gen_byte = head_item.frame[2*BYTE_W-1:BYTE_W];
            gen_next = ST_PXLO;
         end
         ST_PXLO: begin
            gen_byte = head_item.pixel[BYTE_W-1:0];
            gen_crc  = crc_upd;
            gen_next = ST_PXHI;
         end
         ST_PXHI: begin
            gen_byte = head_item.pixel[2*BYTE_W-1:BYTE_W];
            gen_crc  = crc_upd;
            if (head_item.last) begin
               gen_next = ST_CRCLO;
            end else begin
               gen_run_end = 1'b1;
               gen_pop     = 1'b1;
               gen_next    = ST_NEXT;
            end
         end
         ST_CRCLO: begin
            gen_byte = crc_ff[BYTE_W-1:0];
            gen_next = ST_CRCHI;
         end
         ST_CRCHI: begin
            gen_byte      = crc_ff[CRC_W-1:BYTE_W];
            gen_run_end   = 1'b1;
            gen_frame_end = 1'b1;
            gen_pop       = 1'b1;
            gen_crc       = CRC_INIT;
            gen_next      = ST_NEXT;
         end
         default: begin
            gen_next = ST_NEXT;
         end
      endcase
   end

   always_comb begin
      step_in      = step_ff;
      crc_in       = crc_ff;
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      run_end_in   = run_end_ff;
      frame_end_in = frame_end_ff;
      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (fire) begin
         step_in      = gen_next;
         crc_in       = gen_crc;
         out_valid_in = 1'b1;
         out_byte_in  = gen_byte;
         run_end_in   = gen_run_end;
         frame_end_in = gen_frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= ST_NEXT;
         crc_ff       <= CRC_INIT;
         out_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         crc_ff       <= crc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff  <= out_byte_in;
      run_end_ff   <= run_end_in;
      frame_end_ff <= frame_end_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_byte  = out_byte_ff;
   assign rsp_run_end   = run_end_ff;
   assign rsp_frame_end = frame_end_ff;

endmodule

`default_nettype wire

FILE: tb/tb_pixel_frame_packer_crc16_unit.sv
// Self-checking bench for the pixel frame packer: pixel words in, framed byte stream out.
// Needs pfp_pkg and the pixel_frame_packer_crc16_unit RTL; all stimulus is generated here.
`timescale 1ns / 100ps

module tb_pixel_frame_packer_crc16_unit;

   import pfp_pkg::*;

   // About two hundred words; the frame they open stays open at the end.
   localparam int TOTAL_WORDS   = 200;
   localparam int CALM_TAIL     = 60;     // words left in the queue when idling stops
   localparam int PRESS_AFTER   = 40;     // request words accepted before the long hold-off
   localparam int PRESS_CYCLES  = 300;
   localparam int DRAIN_CYCLES  = 24;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic [FRM_W-1:0] frame;
   } pixel_word_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              run_end;
      logic              frame_end;
   } stream_byte_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [PIX_W-1:0]  req_pixel_value = '0;
   logic [FRM_W-1:0]  req_frame_number = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [BYTE_W-1:0] rsp_out_byte;
   logic              rsp_run_end;
   logic              rsp_frame_end;

   pixel_frame_packer_crc16_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pixel_value  (req_pixel_value),
      .req_frame_number (req_frame_number),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_run_end      (rsp_run_end),
      .rsp_frame_end    (rsp_frame_end)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Words waiting to be offered, and bytes the stream should still produce.
   pixel_word_type  pending_words[$];
   stream_byte_type expected_bytes[$];

   // Predictor state: position in the current frame and the running CRC.
   logic [IDX_W-1:0] frame_pos = '0;
   logic [CRC_W-1:0] frame_crc = CRC_INIT;

   logic req_fire  = 1'b0;    // a request word was taken at the last rising edge
   int   words_in  = 0;
   int   fail_count = 0;

   // Idling is switched off for the final stretch so the tail runs at full rate.
   function automatic logic calm_tail();
      return (pending_words.size() < CALM_TAIL);
   endfunction

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   // CRC-16, polynomial 0x1021, fed one data bit at a time, MSB first.
   function automatic logic [CRC_W-1:0] crc16_step(input logic [CRC_W-1:0]  crc,
                                                   input logic [BYTE_W-1:0] data);
      logic [CRC_W-1:0] c;
      logic             fb;
      c = crc;
      for (int i = BYTE_W - 1; i >= 0; i--) begin
         fb = c[CRC_W-1] ^ data[i];
         c  = {c[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
      end
      return c;
   endfunction

   task automatic queue_byte(input logic [BYTE_W-1:0] data, input logic run_end,
                             input logic frame_end);
      stream_byte_type b;
      b.data      = data;
      b.run_end   = run_end;
      b.frame_end = frame_end;
      expected_bytes.push_back(b);
   endtask

   // Work out the bytes one accepted pixel word adds to the stream.
   task automatic pack_pixel(input logic [PIX_W-1:0] pix, input logic [FRM_W-1:0] frm);
      logic closes;
      closes = (frame_pos + 1 >= PIXELS_PER_FRAME);
      if (frame_pos == 0) begin
         // frame start: header, frame number low byte first, CRC reloaded
         queue_byte(SYNC_BYTE, 1'b0, 1'b0);
         queue_byte(SYNC_BYTE, 1'b0, 1'b0);
         queue_byte(frm[7:0], 1'b0, 1'b0);
         queue_byte(frm[15:8], 1'b0, 1'b0);
         frame_crc = CRC_INIT;
      end
      queue_byte(pix[7:0], 1'b0, 1'b0);
      queue_byte(pix[15:8], !closes, 1'b0);
      frame_crc = crc16_step(frame_crc, pix[7:0]);
      frame_crc = crc16_step(frame_crc, pix[15:8]);
      if (closes) begin
         // frame close: CRC trailer, then back to the first pixel position
         queue_byte(frame_crc[7:0], 1'b0, 1'b0);
         queue_byte(frame_crc[15:8], 1'b1, 1'b1);
         frame_pos = '0;
         frame_crc = CRC_INIT;
      end else begin
         frame_pos = frame_pos + 1'b1;
      end
   endtask

   // ------------------------------------------------------------------
   // Request driver: falling edge, fed from pending_words
   // ------------------------------------------------------------------
   pixel_word_type next_word;
   int             send_gap  = 0;
   logic           send_calm = 1'b0;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_fire) begin
         // hold the word until it is taken
      end else if (send_gap > 0) begin
         send_gap--;
         req_valid <= 1'b0;
      end else if (!calm_tail() && !send_calm && $urandom_range(0, 5) == 0) begin
         // open an idle burst, this cycle included
         send_gap = $urandom_range(1, 17) - 1;
         req_valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
         next_word = pending_words.pop_front();
         req_valid        <= 1'b1;
         req_pixel_value  <= next_word.pixel;
         req_frame_number <= next_word.frame;
         if ($urandom_range(0, 63) == 0) send_calm = !send_calm;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // Response receiver: falling edge, random stalls plus one long hold-off
   // ------------------------------------------------------------------
   int   stall_left = 0;
   int   hold_left  = 0;
   logic hold_done  = 1'b0;
   logic recv_calm  = 1'b0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!hold_done && words_in >= PRESS_AFTER) begin
         // back-pressure long enough for the internal queue to fill and stall requests
         hold_done = 1'b1;
         hold_left = PRESS_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!calm_tail() && !recv_calm && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 17) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 149) == 0) recv_calm = !recv_calm;
      end
   end

   // ------------------------------------------------------------------
   // Monitor: rising edge, predict on each request, check each byte
   // ------------------------------------------------------------------
   stream_byte_type want;

   always @(posedge clock) begin
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && req_ready;
         // predict first so a byte in the same edge would still find its entry
         if (req_valid && req_ready) begin
            pack_pixel(req_pixel_value, req_frame_number);
            words_in++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               $error("unexpected byte %02h with nothing outstanding", rsp_out_byte);
               fail_count++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_out_byte !== want.data) begin
                  $error("out_byte: expected %02h, got %02h", want.data, rsp_out_byte);
                  fail_count++;
               end
               if (rsp_run_end !== want.run_end) begin
                  $error("run_end: expected %0b, got %0b", want.run_end, rsp_run_end);
                  fail_count++;
               end
               if (rsp_frame_end !== want.frame_end) begin
                  $error("frame_end: expected %0b, got %0b", want.frame_end, rsp_frame_end);
                  fail_count++;
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------
   function automatic logic [PIX_W-1:0] rand_pixel();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return 16'h8000;
         3:       return 16'h7FFF;
         default: return PIX_W'($urandom_range(0, 65535));
      endcase
   endfunction

   localparam logic [PIX_W-1:0] EDGE_PIXELS [12] = '{
      16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h00FF, 16'hFF00,
      16'h5A5A, 16'hA5A5, 16'h0001, 16'hFFFE, 16'h5A00, 16'h1021
   };

   initial begin
      pixel_word_type w;
      for (int i = 0; i < TOTAL_WORDS; i++) begin
         w.pixel = (i < 12) ? EDGE_PIXELS[i] : rand_pixel();
         // frame number matters only on a frame's first pixel; word 0 gets all ones
         if (i == 0)
            w.frame = '1;
         else if (i == PIXELS_PER_FRAME)
            w.frame = '0;
         else
            w.frame = FRM_W'($urandom_range(0, 65535));
         // closing pixels all-ones, then all-zeros; TOTAL_WORDS stays short of both
         if (i == PIXELS_PER_FRAME - 1) w.pixel = '1;
         if (i == 2 * PIXELS_PER_FRAME - 1) w.pixel = '0;
         pending_words.push_back(w);
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0 || req_valid) @(posedge clock);
      while (expected_bytes.size() != 0) @(posedge clock);
      // give the block time to show any stray bytes
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("tb_pixel_frame_packer_crc16_unit: PASS");
      end else begin
         $display("tb_pixel_frame_packer_crc16_unit: FAIL");
      end
      $finish;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #10_000_000;
      $display("tb_pixel_frame_packer_crc16_unit: FAIL");
      $finish;
   end

endmodule
